// ===== src/fms_pkg.sv =====
// ============================================================================
// fms_pkg: shared constants and types
// Widths, codes and the scan step record used by the free map fit search.
// ============================================================================
`default_nettype none

package fms_pkg;

    localparam int MAP_CELLS = 1024;
    localparam int MAP_AW    = (MAP_CELLS > 1) ? $clog2(MAP_CELLS) : 1;
    localparam int CNT_W     = $clog2(MAP_CELLS + 1);

    localparam int STRAT_W    = 2;
    localparam int ADDR_W     = 16;
    localparam int REGION_W   = 11;
    localparam int REQ_W      = 11;
    localparam int IDX_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_W      = (CNT_W > REQ_W) ? CNT_W : REQ_W;

    localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
    localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_STRATEGY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_CELLS = 2'd2;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    localparam logic [REGION_W-1:0] REGION_RESET = 11'd1024;

    typedef struct packed {
        logic              start;
        logic [REQ_W-1:0]  req;
        logic              valid;
        logic              free;
        logic [MAP_AW-1:0] idx;
    } fms_step_t;

endpackage

`default_nettype wire

// ===== src/fms_if.sv =====
// ============================================================================
// fms_if: channel interfaces
// Valid/ready channels for search and write requests and for search results.
// ============================================================================
`default_nettype none

interface fms_in_if;
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [fms_pkg::IDX_W-1:0]   cell_index;
    logic                        cell_used;
    logic [fms_pkg::REQ_W-1:0]   request_cells;

    modport source (output valid, func, cell_index, cell_used, request_cells,
                    input ready);
    modport sink   (input valid, func, cell_index, cell_used, request_cells,
                    output ready);
endinterface

interface fms_out_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [fms_pkg::ADDR_W-1:0]  run_address;

    modport source (output valid, found, run_address, input ready);
    modport sink   (input valid, found, run_address, output ready);
endinterface

`default_nettype wire

// ===== src/free_map_fit_search_top.sv =====
// ============================================================================
// free_map_fit_search_top: allocation map with first, best and worst fit
// Holds one used/free bit per heap cell in a RAM and searches it for a run
// of free cells by the configured fit rule.
// ============================================================================
//
//   Port     Role     Transaction
//   -------  -------  ------------------------------------------------------
//   in_ch    sink     func, cell_index, cell_used, request_cells
//   out_ch   source   found, run_address (one per search, none per write)
//   cfg_*    write    cfg_index selects strategy, region_base, region_cells
//
// A search reads one map cell per cycle from the RAM port, covering
// min(region_cells, MAP_CELLS) cells, and passes the DRAIN, END and RESULT
// states before its result is loaded into the output register. After reset
// a clearing pass marks every cell free while in_ch.ready stays low. A
// finished search waits while the output register is still full.
//
`default_nettype none

module free_map_fit_search_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [fms_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [fms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    fms_in_if.sink                                  in_ch,
    fms_out_if.source                               out_ch
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_END    = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [fms_pkg::MAP_AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [fms_pkg::CNT_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic                            rd_valid_reg, rd_valid_next;
    logic [fms_pkg::MAP_AW-1:0]      rd_idx_reg, rd_idx_next;
    logic [fms_pkg::STRAT_W-1:0]     strategy_reg;
    logic [fms_pkg::ADDR_W-1:0]      region_base_reg;
    logic [fms_pkg::REGION_W-1:0]    region_cells_reg;
    logic                            out_valid_reg, out_valid_next;
    logic                            found_reg, found_next;
    logic [fms_pkg::ADDR_W-1:0]      run_address_reg, run_address_next;

    logic [fms_pkg::CNT_W-1:0]       limit;
    logic                            in_accept;
    logic                            scan_more;
    logic                            ram_we;
    logic [fms_pkg::MAP_AW-1:0]      ram_addr;
    logic [0:0]                      ram_wdata;
    logic [0:0]                      ram_rdata;
    fms_pkg::fms_step_t              step;
    logic                            fit_found;
    logic [fms_pkg::MAP_AW-1:0]      fit_start;

    assign limit = (fms_pkg::CMP_W'(region_cells_reg) > fms_pkg::CMP_W'(fms_pkg::MAP_CELLS))
        ? fms_pkg::CNT_W'(fms_pkg::MAP_CELLS)
        : fms_pkg::CNT_W'(region_cells_reg);

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign scan_more   = (scan_cnt_reg < limit);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_addr  = scan_cnt_reg[fms_pkg::MAP_AW-1:0];
        if (state_reg == ST_CLEAR)
        begin
            ram_we   = 1'b1;
            ram_addr = clr_cnt_reg;
        end
        else if (state_reg == ST_IDLE)
        begin
            ram_addr  = fms_pkg::MAP_AW'(in_ch.cell_index);
            ram_wdata = in_ch.cell_used;
            ram_we    = in_accept && (in_ch.func == fms_pkg::FUNC_WRITE) &&
                (fms_pkg::CMP_W'(in_ch.cell_index) < fms_pkg::CMP_W'(fms_pkg::MAP_CELLS));
        end
    end

    fms_ram #(
        .WIDTH (1),
        .DEPTH (fms_pkg::MAP_CELLS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        step.start = in_accept && (in_ch.func == fms_pkg::FUNC_SEARCH);
        step.req   = in_ch.request_cells;
        step.valid = rd_valid_reg || (state_reg == ST_END);
        step.free  = rd_valid_reg && !ram_rdata[0];
        step.idx   = rd_idx_reg;
    end

    fms_fit u_fit (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .strategy   (strategy_reg),
        .found      (fit_found),
        .best_start (fit_start)
    );

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        scan_cnt_next    = scan_cnt_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = rd_idx_reg;
        out_valid_next   = out_valid_reg && !out_ch.ready;
        found_next       = found_reg;
        run_address_next = run_address_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == fms_pkg::MAP_AW'(fms_pkg::MAP_CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                scan_cnt_next = '0;
                if (in_accept && (in_ch.func == fms_pkg::FUNC_SEARCH))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_more)
                begin
                    rd_valid_next = 1'b1;
                    rd_idx_next   = scan_cnt_reg[fms_pkg::MAP_AW-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_END;
            end
            ST_END:
            begin
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next   = 1'b1;
                    found_next       = fit_found;
                    run_address_next = fit_found
                        ? region_base_reg + fms_pkg::ADDR_W'(fit_start) : '0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            scan_cnt_reg     <= '0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            strategy_reg     <= fms_pkg::STRAT_FIRST;
            region_base_reg  <= '0;
            region_cells_reg <= fms_pkg::REGION_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    fms_pkg::CFG_STRATEGY:
                        strategy_reg <= cfg_wdata[fms_pkg::STRAT_W-1:0];
                    fms_pkg::CFG_REGION_BASE:
                        region_base_reg <= cfg_wdata[fms_pkg::ADDR_W-1:0];
                    fms_pkg::CFG_REGION_CELLS:
                        region_cells_reg <= cfg_wdata[fms_pkg::REGION_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg      <= rd_idx_next;
        found_reg       <= found_next;
        run_address_reg <= run_address_next;
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.found       = found_reg;
    assign out_ch.run_address = run_address_reg;

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN || state_reg == ST_DRAIN || state_reg == ST_END) |-> !ram_we)
        else $error("map written while a search is running");

    a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(state_reg == ST_SCAN))
        else $error("read data marked valid outside the scan");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (scan_cnt_reg <= limit))
        else $error("scan address ran past the region");

    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !found_reg) |-> (run_address_reg == '0))
        else $error("address given for a search that found nothing");

endmodule

`default_nettype wire

// ===== src/fms_ram.sv =====
// ============================================================================
// fms_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ============================================================================
`default_nettype none

module fms_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

// ===== src/fms_fit.sv =====
// ============================================================================
// fms_fit: free run tracker and fit selection
// Follows the stream of map cells, closes each free run at a used cell or at
// the end of the region, and keeps the run chosen by the fit rule.
// ============================================================================
`default_nettype none

module fms_fit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire fms_pkg::fms_step_t              step,
    input  wire logic [fms_pkg::STRAT_W-1:0]     strategy,
    output logic                                 found,
    output logic      [fms_pkg::MAP_AW-1:0]      best_start
);

    logic [fms_pkg::CNT_W-1:0]  run_len_reg,    run_len_next;
    logic [fms_pkg::MAP_AW-1:0] run_start_reg,  run_start_next;
    logic [fms_pkg::CNT_W-1:0]  best_len_reg,   best_len_next;
    logic [fms_pkg::MAP_AW-1:0] best_start_reg, best_start_next;
    logic                       have_reg,       have_next;
    logic                       done_reg,       done_next;
    logic [fms_pkg::REQ_W-1:0]  req_reg,        req_next;
    logic                       adequate;

    assign adequate = (req_reg != '0) &&
        (fms_pkg::CMP_W'(run_len_reg) >= fms_pkg::CMP_W'(req_reg));

    always_comb
    begin
        run_len_next    = run_len_reg;
        run_start_next  = run_start_reg;
        best_len_next   = best_len_reg;
        best_start_next = best_start_reg;
        have_next       = have_reg;
        done_next       = done_reg;
        req_next        = req_reg;
        if (step.start)
        begin
            run_len_next    = '0;
            run_start_next  = '0;
            best_len_next   = '0;
            best_start_next = '0;
            have_next       = 1'b0;
            done_next       = 1'b0;
            req_next        = step.req;
        end
        else if (step.valid)
        begin
            if (step.free)
            begin
                if (run_len_reg == '0)
                begin
                    run_start_next = step.idx;
                end
                run_len_next = run_len_reg + 1'b1;
            end
            else
            begin
                if (!done_reg && adequate)
                begin
                    unique case (strategy)
                        fms_pkg::STRAT_BEST:
                        begin
                            if (!have_reg || (run_len_reg < best_len_reg))
                            begin
                                have_next       = 1'b1;
                                best_start_next = run_start_reg;
                                best_len_next   = run_len_reg;
                            end
                            if (fms_pkg::CMP_W'(run_len_reg) == fms_pkg::CMP_W'(req_reg))
                            begin
                                done_next = 1'b1;
                            end
                        end
                        fms_pkg::STRAT_WORST:
                        begin
                            if (!have_reg || (run_len_reg > best_len_reg))
                            begin
                                have_next       = 1'b1;
                                best_start_next = run_start_reg;
                                best_len_next   = run_len_reg;
                            end
                        end
                        default:
                        begin
                            have_next       = 1'b1;
                            best_start_next = run_start_reg;
                            best_len_next   = run_len_reg;
                            done_next       = 1'b1;
                        end
                    endcase
                end
                run_len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg    <= '0;
            run_start_reg  <= '0;
            best_len_reg   <= '0;
            best_start_reg <= '0;
            have_reg       <= 1'b0;
            done_reg       <= 1'b0;
            req_reg        <= '0;
        end
        else
        begin
            run_len_reg    <= run_len_next;
            run_start_reg  <= run_start_next;
            best_len_reg   <= best_len_next;
            best_start_reg <= best_start_next;
            have_reg       <= have_next;
            done_reg       <= done_next;
            req_reg        <= req_next;
        end
    end

    assign found      = have_reg;
    assign best_start = best_start_reg;

    a_done_implies_have: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> have_reg)
        else $error("fit search finished without a chosen run");

    a_no_find_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
        (req_reg == '0) |-> !have_reg)
        else $error("run chosen for a zero-size request");

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fms_pkg::CMP_W'(run_len_reg) <= fms_pkg::CMP_W'(fms_pkg::MAP_CELLS))
        else $error("free run longer than the map");

endmodule

`default_nettype wire
